FILE: rtl/xlle_pkg.sv
// Package for the XOR-linked list engine: field widths, operation codes,
// sequencer states, write plans and the memory command struct.
// No dependencies.
package xlle_pkg;

    localparam int unsigned INDEX_W        = 8;
    localparam int unsigned LINK_W         = 8;
    localparam int unsigned NODE_COUNT_DEF = 256;

    typedef enum logic [1:0] {
        OP_APPEND        = 2'd0,
        OP_REMOVE_AFTER  = 2'd1,
        OP_REMOVE_BEFORE = 2'd2,
        OP_READ_LINK     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_C,
        ST_READ_P,
        ST_READ_NX,
        ST_WRITE,
        ST_RESULT
    } t_state;

    typedef enum logic [2:0] {
        PL_APP_HEAD,
        PL_APP_TAIL,
        PL_APP_MID,
        PL_REM_HEAD,
        PL_REM_NOOP,
        PL_REM_TAIL,
        PL_REM_MID
    } t_plan;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

    function automatic logic index_ok(input logic [INDEX_W-1:0] idx,
                                      input int unsigned count);
        return (idx != '0) && (32'(idx) < count);
    endfunction

endpackage

FILE: rtl/xlle_link_mem.sv
// Single-port link memory of the XOR-linked list engine with a clearing sweep after reset.
// Null and out-of-range indices read as zero and drop writes.
// Depends on xlle_pkg.
module xlle_link_mem #(
    parameter int unsigned NODE_COUNT = xlle_pkg::NODE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  xlle_pkg::t_mem_cmd             i_cmd,
    input  logic [xlle_pkg::INDEX_W-1:0]   i_index,
    input  logic [xlle_pkg::LINK_W-1:0]    i_wdata,
    output logic [xlle_pkg::LINK_W-1:0]    o_rdata,
    output logic                           o_ready
);

    localparam int unsigned AW = $clog2(NODE_COUNT);

    logic [xlle_pkg::LINK_W-1:0] r_mem [NODE_COUNT];
    logic [xlle_pkg::LINK_W-1:0] r_rdata;
    logic                        r_rd_ok;
    logic [AW-1:0]               r_clr_addr;
    logic                        r_clearing;
    logic                        w_idx_ok;
    logic [AW-1:0]               w_addr;

    assign w_idx_ok = xlle_pkg::index_ok(i_index, NODE_COUNT);
    assign w_addr   = AW'(i_index);
    assign o_rdata  = r_rd_ok ? r_rdata : '0;
    assign o_ready  = !r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(NODE_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr_en && w_idx_ok) begin
            r_mem[w_addr] <= i_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_addr];
            r_rd_ok <= w_idx_ok;
        end
    end

endmodule

FILE: rtl/xlle_seq.sv
// Operation sequencer of the XOR-linked list engine: reads the links, plans and issues
// the writes, tracks the resulting link of the node and holds the result register.
// Depends on xlle_pkg.
module xlle_seq #(
    parameter int unsigned NODE_COUNT = xlle_pkg::NODE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [23:0]                    i_s_axis_tdata,
    input  logic [1:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [15:0]                    o_m_axis_tdata,
    output xlle_pkg::t_mem_cmd             o_mem_cmd,
    output logic [xlle_pkg::INDEX_W-1:0]   o_mem_index,
    output logic [xlle_pkg::LINK_W-1:0]    o_mem_wdata,
    input  logic [xlle_pkg::LINK_W-1:0]    i_mem_rdata,
    input  logic                           i_mem_ready
);

    localparam logic [1:0] WSTEP_LAST = 2'd2;

    xlle_pkg::t_state r_state, n_state;
    xlle_pkg::t_op    r_op, n_op;
    logic [7:0]       r_node, n_node;
    logic [7:0]       r_nb, n_nb;
    logic [7:0]       r_new, n_new;
    logic [7:0]       r_lc, n_lc;
    logic [7:0]       r_p, n_p;
    logic [7:0]       r_lp, n_lp;
    logic [7:0]       r_nx, n_nx;
    logic [7:0]       r_lnx, n_lnx;
    logic [7:0]       r_link, n_link;
    logic             r_noop, n_noop;
    logic [1:0]       r_wstep, n_wstep;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_link, n_out_link;
    logic             r_out_noop, n_out_noop;

    logic             w_accept;
    logic             w_out_free;
    logic [7:0]       w_in_node;
    logic [7:0]       w_p_next;
    xlle_pkg::t_plan  w_plan;
    logic             w_en;
    logic [7:0]       w_idx;
    logic [7:0]       w_data;

    assign w_in_node       = i_s_axis_tdata[7:0];
    assign o_s_axis_tready = (r_state == xlle_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_noop, r_out_link};

    always_comb begin
        case (r_op)
            xlle_pkg::OP_REMOVE_BEFORE: w_p_next = (r_nb != '0) ? (i_mem_rdata ^ r_nb) : '0;
            default:                    w_p_next = r_nb;
        endcase
    end

    always_comb begin
        case (r_op)
            xlle_pkg::OP_APPEND: begin
                if (r_p == '0 && r_lc != '0) begin
                    w_plan = xlle_pkg::PL_APP_HEAD;
                end else if (r_lc == r_p) begin
                    w_plan = xlle_pkg::PL_APP_TAIL;
                end else begin
                    w_plan = xlle_pkg::PL_APP_MID;
                end
            end
            default: begin
                if (r_p == '0) begin
                    w_plan = (r_lc != '0) ? xlle_pkg::PL_REM_HEAD : xlle_pkg::PL_REM_NOOP;
                end else if (r_lc == r_p) begin
                    w_plan = xlle_pkg::PL_REM_TAIL;
                end else begin
                    w_plan = xlle_pkg::PL_REM_MID;
                end
            end
        endcase
    end

    // Write list of each plan, one entry per step, in the order the writes must land.
    always_comb begin
        w_en   = 1'b0;
        w_idx  = r_node;
        w_data = '0;
        case (w_plan)
            xlle_pkg::PL_APP_HEAD: begin
                w_en = 1'b1;
                case (r_wstep)
                    2'd0:    begin w_idx = r_node; w_data = r_new; end
                    2'd1:    begin w_idx = r_new;  w_data = r_node ^ r_nx; end
                    default: begin w_idx = r_nx;   w_data = r_new ^ r_lnx ^ r_node; end
                endcase
            end
            xlle_pkg::PL_APP_TAIL: begin
                case (r_wstep)
                    2'd0:    begin w_en = 1'b1; w_idx = r_node; w_data = r_p ^ r_new; end
                    2'd1:    begin w_en = 1'b1; w_idx = r_new;  w_data = r_node; end
                    default: w_en = 1'b0;
                endcase
            end
            xlle_pkg::PL_APP_MID: begin
                w_en = 1'b1;
                case (r_wstep)
                    2'd0:    begin w_idx = r_new;  w_data = r_node ^ r_nx; end
                    2'd1:    begin w_idx = r_node; w_data = r_p ^ r_new; end
                    default: begin w_idx = r_nx;   w_data = r_lnx ^ r_node ^ r_new; end
                endcase
            end
            xlle_pkg::PL_REM_HEAD: begin
                case (r_wstep)
                    2'd0:    begin w_en = 1'b1; w_idx = r_nx; w_data = r_lnx ^ r_node; end
                    default: w_en = 1'b0;
                endcase
            end
            xlle_pkg::PL_REM_TAIL: begin
                case (r_wstep)
                    2'd0:    begin w_en = 1'b1; w_idx = r_p;    w_data = r_lp ^ r_node; end
                    2'd1:    begin w_en = 1'b1; w_idx = r_node; w_data = '0; end
                    default: w_en = 1'b0;
                endcase
            end
            xlle_pkg::PL_REM_MID: begin
                case (r_wstep)
                    2'd0: begin
                        w_en   = 1'b1;
                        w_idx  = r_p;
                        w_data = r_lp ^ r_node ^ r_nx;
                    end
                    2'd1: begin
                        w_en   = 1'b1;
                        w_idx  = r_nx;
                        w_data = r_lnx ^ r_node ^ r_p;
                    end
                    default: w_en = 1'b0;
                endcase
            end
            default: w_en = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            xlle_pkg::ST_CLEAR: begin
                if (i_mem_ready) begin
                    n_state = xlle_pkg::ST_IDLE;
                end
            end
            xlle_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = xlle_pkg::index_ok(w_in_node, NODE_COUNT) ?
                              xlle_pkg::ST_READ_C : xlle_pkg::ST_RESULT;
                end
            end
            xlle_pkg::ST_READ_C: begin
                n_state = (r_op == xlle_pkg::OP_READ_LINK) ?
                          xlle_pkg::ST_RESULT : xlle_pkg::ST_READ_P;
            end
            xlle_pkg::ST_READ_P:  n_state = xlle_pkg::ST_READ_NX;
            xlle_pkg::ST_READ_NX: n_state = xlle_pkg::ST_WRITE;
            xlle_pkg::ST_WRITE: begin
                if (r_wstep == WSTEP_LAST) begin
                    n_state = xlle_pkg::ST_RESULT;
                end
            end
            xlle_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_state = xlle_pkg::ST_IDLE;
                end
            end
            default: n_state = xlle_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_mem_cmd   = '0;
        o_mem_index = r_node;
        o_mem_wdata = w_data;
        case (r_state)
            xlle_pkg::ST_IDLE: begin
                o_mem_cmd.rd_en = 1'b1;
                o_mem_index     = w_in_node;
            end
            xlle_pkg::ST_READ_C: begin
                o_mem_cmd.rd_en = 1'b1;
                o_mem_index     = w_p_next;
            end
            xlle_pkg::ST_READ_P: begin
                o_mem_cmd.rd_en = 1'b1;
                o_mem_index     = r_nx;
            end
            xlle_pkg::ST_WRITE: begin
                o_mem_cmd.wr_en = w_en;
                o_mem_index     = w_idx;
            end
            default: o_mem_cmd = '0;
        endcase
    end

    always_comb begin
        n_op        = r_op;
        n_node      = r_node;
        n_nb        = r_nb;
        n_new       = r_new;
        n_lc        = r_lc;
        n_p         = r_p;
        n_lp        = r_lp;
        n_nx        = r_nx;
        n_lnx       = r_lnx;
        n_link      = r_link;
        n_noop      = r_noop;
        n_wstep     = r_wstep;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_link  = r_out_link;
        n_out_noop  = r_out_noop;
        case (r_state)
            xlle_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op   = xlle_pkg::t_op'(i_s_axis_tuser);
                    n_node = w_in_node;
                    n_nb   = i_s_axis_tdata[15:8];
                    n_new  = i_s_axis_tdata[23:16];
                    n_link = '0;
                    n_noop = 1'b0;
                end
            end
            xlle_pkg::ST_READ_C: begin
                n_lc   = i_mem_rdata;
                n_p    = w_p_next;
                n_nx   = i_mem_rdata ^ w_p_next;
                n_link = i_mem_rdata;
            end
            xlle_pkg::ST_READ_P: n_lp = i_mem_rdata;
            xlle_pkg::ST_READ_NX: begin
                n_lnx   = i_mem_rdata;
                n_noop  = (w_plan == xlle_pkg::PL_REM_NOOP);
                n_wstep = '0;
            end
            xlle_pkg::ST_WRITE: begin
                n_wstep = r_wstep + 1'b1;
                if (w_en && w_idx == r_node) begin
                    n_link = w_data;
                end
            end
            xlle_pkg::ST_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_link  = r_link;
                    n_out_noop  = r_noop;
                end
            end
            default: n_wstep = r_wstep;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xlle_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
            r_wstep     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wstep     <= n_wstep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_node     <= n_node;
        r_nb       <= n_nb;
        r_new      <= n_new;
        r_lc       <= n_lc;
        r_p        <= n_p;
        r_lp       <= n_lp;
        r_nx       <= n_nx;
        r_lnx      <= n_lnx;
        r_link     <= n_link;
        r_noop     <= n_noop;
        r_out_link <= n_out_link;
        r_out_noop <= n_out_noop;
    end

endmodule

FILE: rtl/xor_linked_list_engine_core.sv
// Top level of the XOR-linked list engine.
// Instantiates xlle_seq and xlle_link_mem; depends on xlle_pkg.
//
// The block keeps an XOR-linked list in a pool of NODE_COUNT one-byte link words.
// Operations arrive on the slave stream: tuser carries the operation code and tdata
// carries the node, the neighbor and the new node. Each transfer yields exactly one
// result transfer on the master stream with the node's link after the operation and
// a flag that is set when removing a lone head changed nothing.
// Operations run one at a time on a single-port link memory with registered read
// data. Append and both removals pass three dependent link reads, three write slots
// and the result load before the block returns to idle and takes the next input
// transfer. A link read loads its result after the read of the node's link, and an
// operation on the null node loads it straight from idle.
// After reset the memory is cleared one entry per cycle; tready stays low until the
// sweep ends.
// The result sits in an output register, so the next operation is accepted while a
// result waits. When the receiver stalls, a finished operation holds in its last
// state until the output register frees, and tready stays low meanwhile.
module xor_linked_list_engine_core #(
    parameter int unsigned NODE_COUNT = xlle_pkg::NODE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // node_index, neighbor_index, new_node
    input  logic [1:0]  i_s_axis_tuser,   // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // link_out, was_noop, zero fill
);

    xlle_pkg::t_mem_cmd            w_mem_cmd;
    logic [xlle_pkg::INDEX_W-1:0]  w_mem_index;
    logic [xlle_pkg::LINK_W-1:0]   w_mem_wdata;
    logic [xlle_pkg::LINK_W-1:0]   w_mem_rdata;
    logic                          w_mem_ready;

    xlle_seq #(
        .NODE_COUNT (NODE_COUNT)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_mem_cmd       (w_mem_cmd),
        .o_mem_index     (w_mem_index),
        .o_mem_wdata     (w_mem_wdata),
        .i_mem_rdata     (w_mem_rdata),
        .i_mem_ready     (w_mem_ready)
    );

    xlle_link_mem #(
        .NODE_COUNT (NODE_COUNT)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mem_cmd),
        .i_index (w_mem_index),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata),
        .o_ready (w_mem_ready)
    );

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_mem_ready |-> !o_s_axis_tready)
        else $error("input accepted during the memory clearing sweep");

    a_one_op_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("new transfer accepted while an operation is in progress");

    a_noop_has_null_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[8]) |-> (o_m_axis_tdata[7:0] == 8'd0))
        else $error("no-op result reports a non-null link");

    a_no_write_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_cmd.wr_en |-> !o_s_axis_tready)
        else $error("link memory written while the block is idle");
`endif

endmodule

FILE: test/xor_linked_list_engine_core_test.sv
// Self-checking testbench for xor_linked_list_engine_core: a directed table, then random
// list operations, checked against a link-table predictor kept in the testbench.
// Depends on xlle_pkg and the engine RTL.
module xor_linked_list_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import xlle_pkg::*;

    localparam int RANDOM_PER_PHASE = 484;
    localparam int HOLD_CYCLES      = 200;
    localparam int STALL_LIMIT      = 4000;
    localparam int DRAIN_CYCLES     = 24;
    localparam int DIRECTED_ROWS    = 23;

    typedef struct packed {
        logic [7:0] link;
        logic       noop;
    } t_outcome;

    typedef struct packed {
        t_op        op;
        logic [7:0] node;
        logic [7:0] nb;
        logic [7:0] nw;
        logic       typed;
        logic [7:0] link;
        logic       noop;
    } t_row;

    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{OP_READ_LINK,     8'd5,   8'd0,   8'd0,   1'b1, 8'd0,   1'b0},
        '{OP_READ_LINK,     8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   1'b0},
        '{OP_REMOVE_AFTER,  8'd7,   8'd0,   8'd0,   1'b1, 8'd0,   1'b1},
        '{OP_REMOVE_BEFORE, 8'd7,   8'd0,   8'd0,   1'b1, 8'd0,   1'b1},
        '{OP_APPEND,        8'd1,   8'd0,   8'd2,   1'b1, 8'd2,   1'b0},
        '{OP_APPEND,        8'd2,   8'd1,   8'd3,   1'b0, 8'd0,   1'b0},
        '{OP_APPEND,        8'd1,   8'd0,   8'd4,   1'b0, 8'd0,   1'b0},
        '{OP_APPEND,        8'd4,   8'd1,   8'd5,   1'b0, 8'd0,   1'b0},
        '{OP_READ_LINK,     8'd255, 8'd0,   8'd0,   1'b1, 8'd0,   1'b0},
        '{OP_APPEND,        8'd255, 8'd0,   8'd254, 1'b0, 8'd0,   1'b0},
        '{OP_REMOVE_AFTER,  8'd5,   8'd4,   8'd0,   1'b0, 8'd0,   1'b0},
        '{OP_REMOVE_BEFORE, 8'd2,   8'd3,   8'd0,   1'b0, 8'd0,   1'b0},
        '{OP_REMOVE_AFTER,  8'd3,   8'd4,   8'd0,   1'b0, 8'd0,   1'b0},
        '{OP_REMOVE_BEFORE, 8'd4,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
        '{OP_REMOVE_AFTER,  8'd1,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
        '{OP_APPEND,        8'd0,   8'd255, 8'd255, 1'b1, 8'd0,   1'b0},
        '{OP_REMOVE_BEFORE, 8'd0,   8'd1,   8'd1,   1'b1, 8'd0,   1'b0},
        '{OP_APPEND,        8'd10,  8'd0,   8'd0,   1'b0, 8'd0,   1'b0},
        '{OP_REMOVE_BEFORE, 8'd254, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0},
        '{OP_APPEND,        8'd20,  8'd0,   8'd20,  1'b0, 8'd0,   1'b0},
        '{OP_REMOVE_AFTER,  8'd255, 8'd255, 8'd0,   1'b0, 8'd0,   1'b0},
        '{OP_READ_LINK,     8'd20,  8'd255, 8'd255, 1'b0, 8'd0,   1'b0},
        '{OP_APPEND,        8'd128, 8'd127, 8'd64,  1'b0, 8'd0,   1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_tdata = '0;     // node_index, neighbor_index, new_node
    logic [1:0]  s_tuser = '0;     // operation
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_tdata;          // link_out, was_noop, zero fill

    logic [7:0] link_mem [256];
    t_outcome   pending_links [$];
    int         err_count = 0;
    int         quiet_cycles = 0;
    int         snd_idle_pct = 15;
    int         rcv_idle_pct = 78;
    bit         hold_req = 1'b0;

    xor_linked_list_engine_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] link_rd(input logic [7:0] idx);
        return (idx == 8'd0) ? 8'd0 : link_mem[idx];
    endfunction

    function automatic void link_wr(input logic [7:0] idx, input logic [7:0] val);
        if (idx != 8'd0) begin
            link_mem[idx] = val;
        end
    endfunction

    function automatic void insert_after(input logic [7:0] p, input logic [7:0] c,
                                         input logic [7:0] a);
        logic [7:0] nx;
        logic [7:0] nn;
        if (p == 8'd0) begin
            nx = link_rd(c);
            if (nx != 8'd0) begin
                nn = link_rd(nx) ^ c;
                link_wr(c, a);
                link_wr(a, c ^ nx);
                link_wr(nx, a ^ nn);
            end else begin
                link_wr(c, a);
                link_wr(a, c);
            end
        end else if (link_rd(c) == p) begin
            link_wr(c, p ^ a);
            link_wr(a, c);
        end else begin
            nx = link_rd(c) ^ p;
            nn = link_rd(nx) ^ c;
            link_wr(a, c ^ nx);
            link_wr(c, p ^ a);
            link_wr(nx, nn ^ a);
        end
    endfunction

    function automatic logic unlink_after(input logic [7:0] p, input logic [7:0] c);
        logic [7:0] pp;
        logic [7:0] nx;
        logic [7:0] nn;
        if (p == 8'd0) begin
            nx = link_rd(c);
            if (nx == 8'd0) begin
                return 1'b1;
            end
            link_wr(nx, link_rd(nx) ^ c);
        end else if (link_rd(c) == p) begin
            link_wr(p, link_rd(p) ^ c);
            link_wr(c, 8'd0);
        end else begin
            pp = link_rd(p) ^ c;
            nx = link_rd(c) ^ p;
            nn = link_rd(nx) ^ c;
            link_wr(p, pp ^ nx);
            link_wr(nx, nn ^ p);
        end
        return 1'b0;
    endfunction

    function automatic t_outcome list_op_outcome(input t_op op, input logic [7:0] node,
                                                 input logic [7:0] nb, input logic [7:0] nw);
        t_outcome res;
        res = '0;
        if (node == 8'd0) begin
            return res;
        end
        case (op)
            OP_APPEND: begin
                insert_after(nb, node, nw);
            end
            OP_REMOVE_AFTER: begin
                res.noop = unlink_after(nb, node);
            end
            OP_REMOVE_BEFORE: begin
                res.noop = unlink_after((nb != 8'd0) ? (link_rd(node) ^ nb) : 8'd0, node);
            end
            default: ;
        endcase
        res.link = link_rd(node);
        return res;
    endfunction

    task automatic send_op(input t_op op, input logic [7:0] node, input logic [7:0] nb,
                           input logic [7:0] nw, input logic typed, input t_outcome typed_out);
        t_outcome got;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {nw, nb, node};
        do @(posedge clk); while (!s_ready);
        got = list_op_outcome(op, node, nb, nw);
        pending_links.push_back(typed ? typed_out : got);
        @(negedge clk);
    endtask

    always begin
        @(negedge clk);
        if (hold_req) begin
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
        end
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk) begin
        t_outcome want;
        if (rst_n && m_valid && m_ready) begin
            if (pending_links.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected result transfer: data %h", m_tdata);
                end
            end else begin
                want = pending_links.pop_front();
                if (m_tdata[7:0] !== want.link || m_tdata[8] !== want.noop
                        || m_tdata[15:9] !== 7'd0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: link %h noop %b fill %h, expected link %h noop %b",
                                 m_tdata[7:0], m_tdata[8], m_tdata[15:9], want.link, want.noop);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("xor_linked_list_engine_core_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] chain [$];
        bit         in_chain [256];
        bit         wrecked;
        t_op        op;
        logic [7:0] node;
        logic [7:0] nb;
        logic [7:0] nw;
        logic [7:0] pred;
        logic [7:0] succ;
        int         pos;
        int         roll;
        int         pick;
        int         grow;

        foreach (link_mem[i]) begin
            link_mem[i] = 8'd0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            send_op(DIRECTED[r].op, DIRECTED[r].node, DIRECTED[r].nb, DIRECTED[r].nw,
                    DIRECTED[r].typed, '{link: DIRECTED[r].link, noop: DIRECTED[r].noop});
        end

        wrecked = 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            snd_idle_pct = (phase == 0) ? 15 : ((phase == 1) ? 78 : 0);
            rcv_idle_pct = (phase == 0) ? 78 : ((phase == 1) ? 15 : 0);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == 2 && n == 100) begin
                    hold_req = 1'b1;
                end
                // At the start and after a corrupting operation, restart the list from a node that is alone.
                if (wrecked) begin
                    chain.delete();
                    foreach (in_chain[i]) begin
                        in_chain[i] = 1'b0;
                    end
                    node = 8'($urandom_range(1, 255));
                    for (int k = 0; k < 255 && link_mem[node] != 8'd0; k++) begin
                        node = (node == 8'd255) ? 8'd1 : node + 8'd1;
                    end
                    chain.push_back(node);
                    in_chain[node] = 1'b1;
                    wrecked = 1'b0;
                end

                roll = $urandom_range(99);
                nb = 8'($urandom);
                nw = 8'($urandom);
                if (roll < 6) begin
                    op = t_op'($urandom_range(2));
                    node = 8'($urandom);
                    wrecked = 1'b1;
                end else if (roll < 12) begin
                    op = OP_READ_LINK;
                    node = 8'($urandom);
                end else begin
                    pos = $urandom_range(chain.size() - 1);
                    node = chain[pos];
                    pred = (pos == 0) ? 8'd0 : chain[pos - 1];
                    succ = (pos == chain.size() - 1) ? 8'd0 : chain[pos + 1];
                    grow = (chain.size() < 3) ? 70 : ((chain.size() > 40) ? 20 : 45);
                    pick = $urandom_range(99);
                    if (pick < grow) begin
                        op = OP_APPEND;
                        nb = pred;
                        do nw = 8'($urandom_range(1, 255)); while (in_chain[nw]);
                        chain.insert(pos + 1, nw);
                        in_chain[nw] = 1'b1;
                    end else if (pick < grow + 40) begin
                        if (pick < grow + 20) begin
                            op = OP_REMOVE_AFTER;
                            nb = pred;
                        end else begin
                            op = OP_REMOVE_BEFORE;
                            nb = succ;
                        end
                        if (chain.size() > 1) begin
                            chain.delete(pos);
                            in_chain[node] = 1'b0;
                        end
                    end else begin
                        op = OP_READ_LINK;
                    end
                end
                send_op(op, node, nb, nw, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (pending_links.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_links.size() == 0) begin
            $display("xor_linked_list_engine_core_test: done, clean");
        end else begin
            $display("xor_linked_list_engine_core_test: done, errors");
        end
        $finish;
    end

endmodule
